// ===== hw/rtl/avalanche_site_tracker_core_defines.svh =====
// Assertion macros shared by the avalanche site tracker RTL.
// No dependencies; pulled in by the top level with `include.
`ifndef AVALANCHE_SITE_TRACKER_CORE_DEFINES_SVH
`define AVALANCHE_SITE_TRACKER_CORE_DEFINES_SVH

// Clocked check, switched off while reset is held.
`define AVST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same check, also evaluated while reset is held.
`define AVST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/avst_pkg.sv =====
// Types and constants of the avalanche site tracker.
// No dependencies; used by avalanche_site_tracker_core.
package avst_pkg;

    localparam int POS_W      = 6;
    localparam int COL_W      = 10;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 16;
    localparam int DISTINCT_W = 17;
    localparam int TOTAL_W    = 32;
    localparam int RANGE_W    = 17;

    localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
    localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic {
        MODE_SWEEP = 1'b0,
        MODE_RUN   = 1'b1
    } t_mode;

    typedef struct packed {
        logic             occupied;
        logic [POS_W-1:0] low;
        logic [POS_W-1:0] high;
    } t_col_entry;

    localparam int COL_ENTRY_W = $bits(t_col_entry);

endpackage

// ===== hw/rtl/avst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module avst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/avalanche_site_tracker_core.sv =====
// Avalanche site tracker: per-site saturating add counts, per-column low/high surface,
// distinct-site and total-addition counters. One request is taken per cycle while the
// result side drains: a request reads both memories when it is taken, and the update
// stage then updates, writes back and registers the result; a request that hits the
// entry still being written gets the new value forwarded. A clear request, and reset,
// start a sweep through all AXIS_LENGTH*COLUMN_COUNT (65536 by default) site entries,
// which also clears the column memory; no request is taken during it, nor while the
// clear request is in the update stage.
// Depends on avst_pkg, avst_ram and avalanche_site_tracker_core_defines.svh.
`include "avalanche_site_tracker_core_defines.svh"

module avalanche_site_tracker_core #(
    parameter int AXIS_LENGTH  = 64,
    parameter int COLUMN_COUNT = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [avst_pkg::KIND_W-1:0]        i_kind,
    input  logic [avst_pkg::POS_W-1:0]         i_position,
    input  logic [avst_pkg::COL_W-1:0]         i_column,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [avst_pkg::COUNT_W-1:0]       o_site_additions,
    output logic [avst_pkg::DISTINCT_W-1:0]    o_distinct_sites,
    output logic [avst_pkg::TOTAL_W-1:0]       o_total_additions,
    output logic                               o_low_found,
    output logic [avst_pkg::POS_W-1:0]         o_low_position,
    output logic                               o_high_found,
    output logic [avst_pkg::POS_W-1:0]         o_high_position
);

    localparam int SITE_DEPTH = AXIS_LENGTH * COLUMN_COUNT;
    localparam int SITE_AW    = $clog2(SITE_DEPTH);
    localparam int COL_AW     = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam logic [SITE_AW-1:0] SWEEP_LAST = SITE_AW'(SITE_DEPTH - 1);
    localparam logic [SITE_AW-1:0] SWEEP_COLS = SITE_AW'(COLUMN_COUNT);

    // ---------------- request decode ----------------
    logic                  in_accept;
    logic                  in_pos_ok;
    logic                  in_col_ok;
    logic                  in_clear;
    logic                  in_add;
    logic                  in_query;
    logic [SITE_AW-1:0]    in_site_addr;
    logic [COL_AW-1:0]     in_col_addr;

    assign in_accept = i_in_valid && !o_in_stall;
    assign in_pos_ok = avst_pkg::RANGE_W'(i_position) < avst_pkg::RANGE_W'(AXIS_LENGTH);
    assign in_col_ok = avst_pkg::RANGE_W'(i_column) < avst_pkg::RANGE_W'(COLUMN_COUNT);
    assign in_site_addr = SITE_AW'(SITE_AW'(i_column) * SITE_AW'(AXIS_LENGTH))
                        + SITE_AW'(i_position);
    assign in_col_addr = COL_AW'(i_column);

    always_comb begin
        in_clear = 1'b0;
        in_add   = 1'b0;
        in_query = 1'b0;
        unique case (i_kind)
            avst_pkg::KIND_CLEAR: in_clear = 1'b1;
            avst_pkg::KIND_ADD:   in_add   = 1'b1;
            avst_pkg::KIND_QUERY: in_query = 1'b1;
            default: ;
        endcase
    end

    // ---------------- update stage registers ----------------
    logic                          r_s1_valid;
    logic                          r_s1_clear;
    logic                          r_s1_add_ok;
    logic                          r_s1_query;
    logic                          r_s1_col_ok;
    logic [avst_pkg::POS_W-1:0]    r_s1_pos;
    logic [SITE_AW-1:0]            r_s1_site_addr;
    logic [COL_AW-1:0]             r_s1_col_addr;
    logic                          r_s1_site_hit;
    logic [avst_pkg::COUNT_W-1:0]  r_s1_site_fwd;
    logic                          r_s1_col_hit;
    avst_pkg::t_col_entry          r_s1_col_fwd;

    logic [avst_pkg::DISTINCT_W-1:0] r_distinct;
    logic [avst_pkg::DISTINCT_W-1:0] n_distinct;
    logic [avst_pkg::TOTAL_W-1:0]    r_total;
    logic [avst_pkg::TOTAL_W-1:0]    n_total;

    logic                          r_out_valid;
    logic [avst_pkg::COUNT_W-1:0]  r_out_site_additions;
    logic [avst_pkg::DISTINCT_W-1:0] r_out_distinct;
    logic [avst_pkg::TOTAL_W-1:0]  r_out_total;
    logic                          r_out_low_found;
    logic [avst_pkg::POS_W-1:0]    r_out_low_position;
    logic                          r_out_high_found;
    logic [avst_pkg::POS_W-1:0]    r_out_high_position;

    avst_pkg::t_mode               r_mode;
    avst_pkg::t_mode               n_mode;
    logic [SITE_AW-1:0]            r_sweep_idx;
    logic [SITE_AW-1:0]            n_sweep_idx;
    logic                          sweeping;

    // ---------------- memories ----------------
    logic [avst_pkg::COUNT_W-1:0]  site_rdata;
    logic [avst_pkg::COL_ENTRY_W-1:0] col_rdata;
    logic                          site_we;
    logic [SITE_AW-1:0]            site_waddr;
    logic [avst_pkg::COUNT_W-1:0]  site_wdata;
    logic                          col_we;
    logic [COL_AW-1:0]             col_waddr;
    avst_pkg::t_col_entry          col_wdata;

    avst_ram #(
        .WIDTH (avst_pkg::COUNT_W),
        .DEPTH (SITE_DEPTH)
    ) u_site_ram (
        .i_clk   (i_clk),
        .i_we    (site_we),
        .i_waddr (site_waddr),
        .i_wdata (site_wdata),
        .i_re    (in_accept),
        .i_raddr (in_site_addr),
        .o_rdata (site_rdata)
    );

    avst_ram #(
        .WIDTH (avst_pkg::COL_ENTRY_W),
        .DEPTH (COLUMN_COUNT)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_re    (in_accept),
        .i_raddr (in_col_addr),
        .o_rdata (col_rdata)
    );

    // ---------------- update stage logic ----------------
    logic                          s1_fire;
    logic [avst_pkg::COUNT_W-1:0]  site_cur;
    logic [avst_pkg::COUNT_W-1:0]  site_new;
    avst_pkg::t_col_entry          col_cur;
    avst_pkg::t_col_entry          col_new;
    logic                          s1_write;
    logic                          q_low_found;
    logic                          q_high_found;

    assign s1_fire  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_write = s1_fire && r_s1_add_ok;

    assign site_cur = r_s1_site_hit ? r_s1_site_fwd : site_rdata;
    assign col_cur  = r_s1_col_hit ? r_s1_col_fwd : avst_pkg::t_col_entry'(col_rdata);
    assign site_new = (site_cur == avst_pkg::COUNT_MAX) ? site_cur
                                                        : site_cur + avst_pkg::COUNT_W'(1);

    always_comb begin
        col_new = col_cur;
        if (!col_cur.occupied) begin
            col_new.occupied = 1'b1;
            col_new.low      = r_s1_pos;
            col_new.high     = r_s1_pos;
        end else begin
            if (r_s1_pos < col_cur.low) begin
                col_new.low = r_s1_pos;
            end
            if (r_s1_pos > col_cur.high) begin
                col_new.high = r_s1_pos;
            end
        end
    end

    assign q_low_found  = r_s1_query && r_s1_col_ok && col_cur.occupied;
    assign q_high_found = q_low_found && (col_cur.high != col_cur.low);

    always_comb begin
        n_distinct = r_distinct;
        n_total    = r_total;
        if (r_s1_clear) begin
            n_distinct = '0;
            n_total    = '0;
        end else if (r_s1_add_ok) begin
            if (site_cur == '0 && r_distinct != avst_pkg::DISTINCT_MAX) begin
                n_distinct = r_distinct + avst_pkg::DISTINCT_W'(1);
            end
            if (r_total != avst_pkg::TOTAL_MAX) begin
                n_total = r_total + avst_pkg::TOTAL_W'(1);
            end
        end
    end

    // memory write ports: sweep has the port to itself
    always_comb begin
        if (sweeping) begin
            site_we    = 1'b1;
            site_waddr = r_sweep_idx;
            site_wdata = '0;
            col_we     = r_sweep_idx < SWEEP_COLS;
            col_waddr  = r_sweep_idx[COL_AW-1:0];
            col_wdata  = '0;
        end else begin
            site_we    = s1_write;
            site_waddr = r_s1_site_addr;
            site_wdata = site_new;
            col_we     = s1_write;
            col_waddr  = r_s1_col_addr;
            col_wdata  = col_new;
        end
    end

    // ---------------- sweep controller ----------------
    always_comb begin
        n_mode      = r_mode;
        n_sweep_idx = r_sweep_idx;
        unique case (r_mode)
            avst_pkg::MODE_SWEEP: begin
                if (r_sweep_idx == SWEEP_LAST) begin
                    n_mode      = avst_pkg::MODE_RUN;
                    n_sweep_idx = '0;
                end else begin
                    n_sweep_idx = r_sweep_idx + SITE_AW'(1);
                end
            end
            avst_pkg::MODE_RUN: begin
                if (s1_fire && r_s1_clear) begin
                    n_mode = avst_pkg::MODE_SWEEP;
                end
            end
            default: n_mode = avst_pkg::MODE_SWEEP;
        endcase
    end

    always_comb begin
        sweeping   = (r_mode == avst_pkg::MODE_SWEEP);
        // a clear in the update stage holds off requests until the sweep starts
        o_in_stall = sweeping || (r_s1_valid && (r_s1_clear || !s1_fire));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= avst_pkg::MODE_SWEEP;
            r_sweep_idx <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_distinct  <= '0;
            r_total     <= '0;
        end else begin
            r_mode      <= n_mode;
            r_sweep_idx <= n_sweep_idx;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_distinct  <= n_distinct;
                r_total     <= n_total;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the update stage; forwarding catches the write landing with our read
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_clear     <= in_clear;
            r_s1_add_ok    <= in_add && in_pos_ok && in_col_ok;
            r_s1_query     <= in_query;
            r_s1_col_ok    <= in_col_ok;
            r_s1_pos       <= i_position;
            r_s1_site_addr <= in_site_addr;
            r_s1_col_addr  <= in_col_addr;
            r_s1_site_hit  <= s1_write && (r_s1_site_addr == in_site_addr);
            r_s1_site_fwd  <= site_new;
            r_s1_col_hit   <= s1_write && (r_s1_col_addr == in_col_addr);
            r_s1_col_fwd   <= col_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_site_additions <= r_s1_add_ok ? site_new : '0;
            r_out_distinct       <= n_distinct;
            r_out_total          <= n_total;
            r_out_low_found      <= q_low_found;
            r_out_low_position   <= q_low_found ? col_cur.low : '0;
            r_out_high_found     <= q_high_found;
            r_out_high_position  <= q_high_found ? col_cur.high : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_site_additions  = r_out_site_additions;
    assign o_distinct_sites  = r_out_distinct;
    assign o_total_additions = r_out_total;
    assign o_low_found       = r_out_low_found;
    assign o_low_position    = r_out_low_position;
    assign o_high_found      = r_out_high_found;
    assign o_high_position   = r_out_high_position;

    // ---------------- assertions ----------------
    `AVST_ASSERT(a_distinct_le_total, avst_pkg::TOTAL_W'(r_distinct) <= r_total, "distinct sites exceed additions")
    `AVST_ASSERT(a_sweep_counters_zero, sweeping |-> (r_distinct == '0 && r_total == '0), "counters moved during clear sweep")
    `AVST_ASSERT(a_no_accept_in_sweep, sweeping |-> !in_accept, "request taken during clear sweep")
    `AVST_ASSERT(a_add_counted, (r_out_valid && r_out_site_additions != '0) |-> (r_out_total != '0), "site count without total")

endmodule

// ===== tb/sv/avalanche_site_tracker_checker.sv =====
// Checker for the avalanche site tracker: watches both channels, predicts each result
// from its own copy of the site counts, column surface and counters, and compares.
// Depends on avst_pkg; instantiated beside the block by avalanche_site_tracker_core_tb.
module avalanche_site_tracker_checker
    import avst_pkg::*;
#(
    parameter int AXIS_LENGTH  = 64,
    parameter int COLUMN_COUNT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [POS_W-1:0]      i_position,
    input  logic [COL_W-1:0]      i_column,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [COUNT_W-1:0]    i_site_additions,
    input  logic [DISTINCT_W-1:0] i_distinct_sites,
    input  logic [TOTAL_W-1:0]    i_total_additions,
    input  logic                  i_low_found,
    input  logic [POS_W-1:0]      i_low_position,
    input  logic                  i_high_found,
    input  logic [POS_W-1:0]      i_high_position,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SITE_TOTAL = AXIS_LENGTH * COLUMN_COUNT;

    typedef struct packed {
        logic [COUNT_W-1:0]    site_additions;
        logic [DISTINCT_W-1:0] distinct_sites;
        logic [TOTAL_W-1:0]    total_additions;
        logic                  low_found;
        logic [POS_W-1:0]      low_position;
        logic                  high_found;
        logic [POS_W-1:0]      high_position;
    } t_site_report;

    logic [COUNT_W-1:0]    site_tally [SITE_TOTAL];
    logic [POS_W-1:0]      col_low [COLUMN_COUNT];
    logic [POS_W-1:0]      col_high [COLUMN_COUNT];
    logic                  col_used [COLUMN_COUNT];
    logic [DISTINCT_W-1:0] distinct_tally;
    logic [TOTAL_W-1:0]    addition_tally;
    t_site_report          expected_reports [$];
    int                    fail_count = 0;

    function automatic void wipe_tracker();
        foreach (site_tally[i]) site_tally[i] = '0;
        foreach (col_used[i]) begin
            col_used[i] = 1'b0;
            col_low[i]  = '0;
            col_high[i] = '0;
        end
        distinct_tally = '0;
        addition_tally = '0;
    endfunction

    function automatic t_site_report apply_request(input logic [KIND_W-1:0] kind,
                                                   input logic [POS_W-1:0]  pos,
                                                   input logic [COL_W-1:0]  col);
        t_site_report       rep;
        int                 idx;
        logic [COUNT_W-1:0] tally;
        rep = '0;
        case (kind)
            KIND_CLEAR: begin
                wipe_tracker();
            end
            KIND_ADD: begin
                // out-of-range sites are dropped without touching any counter
                if (int'(pos) < AXIS_LENGTH && int'(col) < COLUMN_COUNT) begin
                    idx   = int'(col) * AXIS_LENGTH + int'(pos);
                    tally = site_tally[idx];
                    if (tally == '0 && distinct_tally != DISTINCT_MAX) distinct_tally++;
                    if (tally != COUNT_MAX) tally++;
                    site_tally[idx]    = tally;
                    rep.site_additions = tally;
                    if (addition_tally != TOTAL_MAX) addition_tally++;
                    if (!col_used[col]) begin
                        col_used[col] = 1'b1;
                        col_low[col]  = pos;
                        col_high[col] = pos;
                    end else begin
                        if (pos < col_low[col]) col_low[col] = pos;
                        if (pos > col_high[col]) col_high[col] = pos;
                    end
                end
            end
            KIND_QUERY: begin
                if (int'(col) < COLUMN_COUNT && col_used[col]) begin
                    rep.low_found    = 1'b1;
                    rep.low_position = col_low[col];
                    if (col_high[col] != col_low[col]) begin
                        rep.high_found    = 1'b1;
                        rep.high_position = col_high[col];
                    end
                end
            end
            default: begin
            end
        endcase
        rep.distinct_sites  = distinct_tally;
        rep.total_additions = addition_tally;
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_report();
        t_site_report want;
        if (expected_reports.size() == 0) begin
            report_mismatch("result with no request pending", 64'(i_total_additions), 64'd0);
            return;
        end
        want = expected_reports.pop_front();
        check_field("site_additions", 64'(i_site_additions), 64'(want.site_additions));
        check_field("distinct_sites", 64'(i_distinct_sites), 64'(want.distinct_sites));
        check_field("total_additions", 64'(i_total_additions), 64'(want.total_additions));
        check_field("low_found", 64'(i_low_found), 64'(want.low_found));
        check_field("low_position", 64'(i_low_position), 64'(want.low_position));
        check_field("high_found", 64'(i_high_found), 64'(want.high_found));
        check_field("high_position", 64'(i_high_position), 64'(want.high_position));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_tracker();
            expected_reports.delete();
        end else begin
            // results first: a request taken at this edge cannot answer at the same edge
            if (i_out_valid && !i_out_stall) check_report();
            if (i_in_valid && !i_in_stall)
                expected_reports.insert(expected_reports.size(),
                                        apply_request(i_kind, i_position, i_column));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_reports.size();
    end

endmodule

// ===== tb/sv/avalanche_site_tracker_core_tb.sv =====
// Top of the avalanche site tracker testbench: clock, reset, request stimulus and
// result-side stalls; the verdict comes from avalanche_site_tracker_checker.
// Depends on avst_pkg, avalanche_site_tracker_core and avalanche_site_tracker_checker.
module avalanche_site_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import avst_pkg::*;

    localparam int                CLK_PERIOD    = 4;
    localparam int                AXIS_LENGTH   = 64;
    localparam int                COLUMN_COUNT  = 1024;
    localparam int                RANDOM_ITEMS  = 1500;
    localparam int                FINAL_ADDS    = 256;
    localparam int                FINAL_QUERIES = 64;
    localparam int                HOLD_CYCLES   = 150;
    localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;
    localparam logic [COL_W-1:0]  BAND_COL      = 10'd700;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  in_stall;
    logic [KIND_W-1:0]     req_kind;
    logic [POS_W-1:0]      req_position;
    logic [COL_W-1:0]      req_column;
    logic                  res_valid;
    logic                  res_stall;
    logic [COUNT_W-1:0]    res_site_additions;
    logic [DISTINCT_W-1:0] res_distinct_sites;
    logic [TOTAL_W-1:0]    res_total_additions;
    logic                  res_low_found;
    logic [POS_W-1:0]      res_low_position;
    logic                  res_high_found;
    logic [POS_W-1:0]      res_high_position;
    int                    fail_count;
    int                    pending;

    bit                    sender_gaps = 1'b0;
    bit                    stall_gaps  = 1'b1;
    int                    hold_asks   = 0;
    int                    hold_done   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    avalanche_site_tracker_core #(
        .AXIS_LENGTH  (AXIS_LENGTH),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .o_in_stall        (in_stall),
        .i_kind            (req_kind),
        .i_position        (req_position),
        .i_column          (req_column),
        .o_out_valid       (res_valid),
        .i_out_stall       (res_stall),
        .o_site_additions  (res_site_additions),
        .o_distinct_sites  (res_distinct_sites),
        .o_total_additions (res_total_additions),
        .o_low_found       (res_low_found),
        .o_low_position    (res_low_position),
        .o_high_found      (res_high_found),
        .o_high_position   (res_high_position)
    );

    avalanche_site_tracker_checker #(
        .AXIS_LENGTH  (AXIS_LENGTH),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) site_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .i_in_stall        (in_stall),
        .i_kind            (req_kind),
        .i_position        (req_position),
        .i_column          (req_column),
        .i_out_valid       (res_valid),
        .i_out_stall       (res_stall),
        .i_site_additions  (res_site_additions),
        .i_distinct_sites  (res_distinct_sites),
        .i_total_additions (res_total_additions),
        .i_low_found       (res_low_found),
        .i_low_position    (res_low_position),
        .i_high_found      (res_high_found),
        .i_high_position   (res_high_position),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // result-side stalls: random bursts, plus one long hold-off on request
    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_done != hold_asks) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_stall <= 1'b0;
                hold_done = hold_asks;
            end else if (stall_gaps && $urandom_range(0, 4) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                res_stall <= 1'b0;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [COL_W-1:0] col);
        @(negedge clk);
        req_valid    <= 1'b1;
        req_kind     <= kind;
        req_position <= pos;
        req_column   <= col;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        idle_sender(1);
        wait (pending == 0);
    endtask

    task automatic clear_avalanche();
        drain();
        send_request(KIND_CLEAR, POS_W'($urandom_range(0, 63)),
                     COL_W'($urandom_range(0, 1023)));
    endtask

    initial begin
        int                   col_base;
        int                   pick;
        logic [KIND_W-1:0]    kind;
        logic [POS_W-1:0]     pos;
        logic [COL_W-1:0]     col;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_kind     = KIND_CLEAR;
        req_position = '0;
        req_column   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty columns, edges of both axes, repeated site, ignored kind
        send_request(KIND_QUERY, 6'd0, 10'd0);
        send_request(KIND_QUERY, 6'd63, 10'd1023);
        send_request(KIND_ADD, 6'd0, 10'd0);
        send_request(KIND_ADD, 6'd0, 10'd0);
        send_request(KIND_ADD, 6'd63, 10'd1023);
        send_request(KIND_ADD, 6'd63, 10'd0);
        send_request(KIND_QUERY, 6'd0, 10'd0);
        send_request(KIND_QUERY, 6'd0, 10'd1023);
        send_request(KIND_ADD, 6'd31, 10'd1023);
        send_request(KIND_QUERY, 6'd0, 10'd1023);
        send_request(KIND_ADD, 6'd5, 10'd512);
        send_request(KIND_QUERY, 6'd0, 10'd512);
        send_request(KIND_SPARE, 6'd63, 10'd1023);
        send_request(KIND_SPARE, 6'd0, 10'd0);
        send_request(KIND_ADD, 6'd42, 10'h2AA);
        send_request(KIND_ADD, 6'd21, 10'h155);
        send_request(KIND_ADD, 6'd21, 10'h2AA);
        send_request(KIND_QUERY, 6'd63, 10'h2AA);
        send_request(KIND_QUERY, 6'd0, 10'h155);
        send_request(KIND_QUERY, 6'd0, 10'd1);
        clear_avalanche();
        send_request(KIND_QUERY, 6'd0, 10'd0);
        send_request(KIND_ADD, 6'd63, 10'd0);
        send_request(KIND_ADD, 6'd63, 10'd0);
        send_request(KIND_QUERY, 6'd0, 10'd0);

        // random: mostly a narrow band of columns so sites repeat and surfaces move
        sender_gaps = 1'b1;
        col_base    = int'($urandom_range(0, 1016));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 460 == 459) begin
                clear_avalanche();
                col_base = int'($urandom_range(0, 1016));
            end
            if (n == 300 || n == 1300) hold_asks++;

            pick = $urandom_range(0, 99);
            if (pick < 55)      kind = KIND_ADD;
            else if (pick < 92) kind = KIND_QUERY;
            else                kind = KIND_SPARE;

            pick = $urandom_range(0, 99);
            if (pick < 75)      col = COL_W'(col_base + int'($urandom_range(0, 7)));
            else if (pick < 80) col = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
            else                col = COL_W'($urandom_range(0, 1023));

            pick = $urandom_range(0, 9);
            if (pick == 0)      pos = 6'd0;
            else if (pick == 1) pos = 6'd63;
            else                pos = POS_W'($urandom_range(0, 63));

            // hold-off stretches run with a steady sender so the block backs up
            if (sender_gaps && hold_done == hold_asks && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 8));
            send_request(kind, pos, col);
        end

        // final part, no idling: back-to-back adds into a few columns, then read a
        // stretch of columns starting at the first of them
        sender_gaps = 1'b0;
        stall_gaps  = 1'b0;
        clear_avalanche();
        for (int k = 0; k < FINAL_ADDS; k++)
            send_request(KIND_ADD, POS_W'($urandom_range(0, 63)), BAND_COL + COL_W'(k % 4));
        for (int k = 0; k < FINAL_QUERIES; k++)
            send_request(KIND_QUERY, POS_W'($urandom_range(0, 63)), BAND_COL + COL_W'(k));

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
